/* design/vl2n_pkg.sv */
// Shared types and constants for the vector L2 normalisation block.
// Used by the top level and the square root unit; depends on nothing.

package vl2n_pkg;

    localparam int DEF_MAX_LENGTH   = 16;
    localparam int DEF_ELEMENT_BITS = 16;

    localparam int LEN_BITS  = 5;
    localparam int SUM_BITS  = 36;
    localparam int ROOT_BITS = SUM_BITS / 2;
    localparam int NORM_BITS = 17;
    localparam int UNIT_BITS = 16;
    localparam int FRAC_BITS = 15;

    localparam logic [LEN_BITS-1:0]  LEN_RESET = LEN_BITS'(16);
    localparam logic [NORM_BITS-1:0] NORM_MAX  = {NORM_BITS{1'b1}};
    localparam logic [UNIT_BITS-1:0] UNIT_POS_MAX = {1'b0, {(UNIT_BITS-1){1'b1}}};
    localparam logic [UNIT_BITS-1:0] UNIT_NEG_MAG = {1'b1, {(UNIT_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_READ,
        ST_PREP,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage

/* design/vl2n_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.

module vl2n_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/vl2n_sqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
// Depends on vl2n_pkg.

module vl2n_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vl2n_pkg::SUM_BITS-1:0] radicand,
    output logic [vl2n_pkg::ROOT_BITS-1:0] root,
    output logic                          done
);

    import vl2n_pkg::*;

    localparam int STEPS     = SUM_BITS / 2;
    localparam int REM_BITS  = ROOT_BITS + 3;
    localparam int STEP_BITS = $clog2(STEPS + 1);

    logic [SUM_BITS-1:0]  rad_reg, rad_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;

    logic [REM_BITS-1:0] rem_shift;
    logic [REM_BITS-1:0] trial;

    always_comb
    begin
        rem_shift = {rem_reg[REM_BITS-3:0], rad_reg[SUM_BITS-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = STEP_BITS'(STEPS);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rad_next  = {rad_reg[SUM_BITS-3:0], 2'b00};
            step_next = step_reg - STEP_BITS'(1);
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
            end
            if (step_reg == STEP_BITS'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

/* design/vector_l2_normalize_top.sv */
// Top level of the vector L2 normalisation block: control, element RAM and divider.
// Depends on vl2n_pkg, vl2n_ram and vl2n_sqrt.

// Elements are taken one per request while busy is low; each request keeps busy high
// while it is stored and its square is accumulated. The request that completes the
// vector then starts an 18-step square root, which keeps busy high, after which one
// result per element leaves on result_valid, each after a RAM read, set-up, a 16-step
// restoring divide and output; an all-zero vector or a saturating element skips the
// divide. Each result is shown for exactly one cycle and cannot be held off. busy stays
// high until the last result of the vector has been issued.

module vector_l2_normalize_top #(
    parameter int MAX_LENGTH   = vl2n_pkg::DEF_MAX_LENGTH,
    parameter int ELEMENT_BITS = vl2n_pkg::DEF_ELEMENT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [ELEMENT_BITS-1:0] element_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vl2n_pkg::LEN_BITS-1:0]  cfg_data,
    output logic                           result_valid,
    output logic signed [vl2n_pkg::UNIT_BITS-1:0] unit_element,
    output logic [vl2n_pkg::NORM_BITS-1:0] norm_value,
    output logic                           zero_norm,
    output logic                           last_element
);

    import vl2n_pkg::*;

    localparam int ADDR_BITS = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CNT_BITS  = $clog2(MAX_LENGTH + 1);
    localparam int EFF_BITS  = (CNT_BITS > LEN_BITS) ? CNT_BITS : LEN_BITS;
    localparam int PROD_BITS = 2 * ELEMENT_BITS;
    localparam int CMP_BITS  = (ELEMENT_BITS > NORM_BITS + 1) ? ELEMENT_BITS : NORM_BITS + 1;
    localparam int DIV_STEPS = UNIT_BITS;
    localparam int DIV_BITS  = $clog2(DIV_STEPS + 1);

    state_t state_reg, state_next;

    logic [LEN_BITS-1:0]     length_reg, length_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;
    logic [CNT_BITS-1:0]     index_reg, index_next;
    logic                    complete_reg, complete_next;
    logic [ELEMENT_BITS-1:0] mag_reg, mag_next;
    logic [PROD_BITS-1:0]    prod_reg, prod_next;
    logic [SUM_BITS-1:0]     sum_reg, sum_next;
    logic [NORM_BITS-1:0]    norm_reg, norm_next;
    logic                    zero_reg, zero_next;
    logic                    neg_reg, neg_next;
    logic                    sat_reg, sat_next;
    logic [NORM_BITS-1:0]    rem_reg, rem_next;
    logic [UNIT_BITS-1:0]    quo_reg, quo_next;
    logic [UNIT_BITS-1:0]    dbits_reg, dbits_next;
    logic [DIV_BITS-1:0]     step_reg, step_next;
    logic                    valid_reg, valid_next;
    logic [UNIT_BITS-1:0]    unit_reg, unit_next;
    logic [NORM_BITS-1:0]    out_norm_reg, out_norm_next;
    logic                    out_zero_reg, out_zero_next;
    logic                    out_last_reg, out_last_next;

    logic                    accept;
    logic [EFF_BITS-1:0]     eff_length;
    logic [CNT_BITS-1:0]     count_inc;
    logic [CNT_BITS-1:0]     index_inc;
    logic                    is_last;
    logic                    ram_we;
    logic [ADDR_BITS-1:0]    ram_addr;
    logic [ELEMENT_BITS-1:0] ram_rdata;
    logic                    sqrt_start;
    logic                    sqrt_done;
    logic [ROOT_BITS-1:0]    sqrt_root;
    logic                    rd_neg;
    logic [ELEMENT_BITS-1:0] rd_mag;
    logic [NORM_BITS:0]      rem_shift;
    logic [UNIT_BITS-1:0]    quo_clip;

    function automatic logic [ELEMENT_BITS-1:0] magnitude(input logic [ELEMENT_BITS-1:0] v);
        return v[ELEMENT_BITS-1] ? (~v + ELEMENT_BITS'(1)) : v;
    endfunction

    vl2n_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (MAX_LENGTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (element_value),
        .rdata (ram_rdata)
    );

    vl2n_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && (state_reg == ST_IDLE);
    assign count_inc = count_reg + CNT_BITS'(1);
    assign index_inc = index_reg + CNT_BITS'(1);
    assign is_last   = (index_inc == count_reg);

    always_comb
    begin
        if (length_reg == '0)
        begin
            eff_length = EFF_BITS'(1);
        end
        else if (EFF_BITS'(length_reg) > EFF_BITS'(MAX_LENGTH))
        begin
            eff_length = EFF_BITS'(MAX_LENGTH);
        end
        else
        begin
            eff_length = EFF_BITS'(length_reg);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = complete_reg ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT:
            begin
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (zero_reg || (CMP_BITS'(rd_mag) >= CMP_BITS'({norm_reg, 1'b0})))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (step_reg == DIV_BITS'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                state_next = is_last ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        rd_neg     = ram_rdata[ELEMENT_BITS-1];
        rd_mag     = magnitude(ram_rdata);
        rem_shift  = {rem_reg, dbits_reg[UNIT_BITS-1]};
        quo_clip   = (quo_reg > UNIT_NEG_MAG) ? UNIT_NEG_MAG : quo_reg;

        length_next   = (cfg_valid && cfg_ready) ? cfg_data : length_reg;
        count_next    = count_reg;
        index_next    = index_reg;
        complete_next = complete_reg;
        mag_next      = mag_reg;
        prod_next     = prod_reg;
        sum_next      = sum_reg;
        norm_next     = norm_reg;
        zero_next     = zero_reg;
        neg_next      = neg_reg;
        sat_next      = sat_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dbits_next    = dbits_reg;
        step_next     = step_reg;
        valid_next    = 1'b0;
        unit_next     = unit_reg;
        out_norm_next = out_norm_reg;
        out_zero_next = out_zero_reg;
        out_last_next = out_last_reg;
        ram_we        = 1'b0;
        ram_addr      = index_reg[ADDR_BITS-1:0];
        sqrt_start    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ram_we        = 1'b1;
                    ram_addr      = count_reg[ADDR_BITS-1:0];
                    mag_next      = magnitude(element_value);
                    complete_next = (EFF_BITS'(count_inc) >= eff_length);
                    count_next    = count_inc;
                end
            end
            ST_SQUARE:
            begin
                prod_next = mag_reg * mag_reg;
            end
            ST_ACCUM:
            begin
                sum_next   = sum_reg + SUM_BITS'(prod_reg);
                index_next = '0;
            end
            ST_ROOT:
            begin
                sqrt_start = 1'b1;
            end
            ST_ROOT_WAIT:
            begin
                if (sqrt_done)
                begin
                    norm_next = (sqrt_root > ROOT_BITS'(NORM_MAX)) ? NORM_MAX
                                                                  : sqrt_root[NORM_BITS-1:0];
                    zero_next = (sum_reg == '0);
                end
            end
            ST_READ:
            begin
            end
            ST_PREP:
            begin
                neg_next   = rd_neg;
                sat_next   = (CMP_BITS'(rd_mag) >= CMP_BITS'({norm_reg, 1'b0}));
                rem_next   = NORM_BITS'(rd_mag >> 1);
                dbits_next = {rd_mag[0], {FRAC_BITS{1'b0}}};
                quo_next   = '0;
                step_next  = DIV_BITS'(DIV_STEPS);
            end
            ST_DIVIDE:
            begin
                dbits_next = {dbits_reg[UNIT_BITS-2:0], 1'b0};
                step_next  = step_reg - DIV_BITS'(1);
                if (rem_shift >= {1'b0, norm_reg})
                begin
                    rem_next = NORM_BITS'(rem_shift - {1'b0, norm_reg});
                    quo_next = {quo_reg[UNIT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[NORM_BITS-1:0];
                    quo_next = {quo_reg[UNIT_BITS-2:0], 1'b0};
                end
            end
            ST_EMIT:
            begin
                valid_next    = 1'b1;
                out_last_next = is_last;
                out_zero_next = zero_reg;
                out_norm_next = zero_reg ? '0 : norm_reg;
                if (zero_reg)
                begin
                    unit_next = '0;
                end
                else if (neg_reg)
                begin
                    unit_next = sat_reg ? UNIT_NEG_MAG : (UNIT_BITS'(0) - quo_clip);
                end
                else
                begin
                    unit_next = (sat_reg || quo_reg[UNIT_BITS-1]) ? UNIT_POS_MAX : quo_reg;
                end
                index_next = index_inc;
                if (is_last)
                begin
                    sum_next   = '0;
                    count_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            length_reg   <= LEN_RESET;
            count_reg    <= '0;
            index_reg    <= '0;
            complete_reg <= 1'b0;
            sum_reg      <= '0;
            norm_reg     <= '0;
            zero_reg     <= 1'b0;
            step_reg     <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            index_reg    <= index_next;
            complete_reg <= complete_next;
            sum_reg      <= sum_next;
            norm_reg     <= norm_next;
            zero_reg     <= zero_next;
            step_reg     <= step_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        sat_reg      <= sat_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dbits_reg    <= dbits_next;
        unit_reg     <= unit_next;
        out_norm_reg <= out_norm_next;
        out_zero_reg <= out_zero_next;
        out_last_reg <= out_last_next;
    end

    assign result_valid = valid_reg;
    assign unit_element = unit_reg;
    assign norm_value   = out_norm_reg;
    assign zero_norm    = out_zero_reg;
    assign last_element = out_last_reg;

endmodule

/* verif/vector_l2_normalize_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for vector_l2_normalize_top: element requests, length writes and
// a predictor of the norm and the Q1.15 quotients, checked result by result.
// Depends on vl2n_pkg and the design under verif's sibling design folder.

module vector_l2_normalize_top_test;

    import vl2n_pkg::*;

    localparam int MAX_ELEMS     = DEF_MAX_LENGTH;
    localparam int ELEM_BITS     = DEF_ELEMENT_BITS;
    localparam int RANDOM_ITEMS  = 290;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [UNIT_BITS-1:0] unit;
        logic [NORM_BITS-1:0] norm;
        logic                 zero;
        logic                 last;
    } unit_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [ELEM_BITS-1:0] element_value;
    logic cfg_valid;
    logic cfg_ready;
    logic [LEN_BITS-1:0] cfg_data;
    logic result_valid;
    logic signed [UNIT_BITS-1:0] unit_element;
    logic [NORM_BITS-1:0] norm_value;
    logic zero_norm;
    logic last_element;

    unit_result_t pending_units[$];
    logic [ELEM_BITS-1:0] elem_mem [0:MAX_ELEMS-1];
    logic [SUM_BITS-1:0] square_acc;
    int loaded_count;
    logic [LEN_BITS-1:0] length_reg;

    int error_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int vectors_done = 0;
    int cfg_writes = 0;
    int cycle_count = 0;
    int burst_left = 0;

    vector_l2_normalize_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .element_value(element_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .unit_element (unit_element),
        .norm_value   (norm_value),
        .zero_norm    (zero_norm),
        .last_element (last_element)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_units.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("Mismatch on result %0d: %s, got %0d, expected %0d.",
                 results_seen, what, got, want);
        error_count++;
    endtask

    function automatic int effective_len(input logic [LEN_BITS-1:0] n);
        if (n == 0)
            return 1;
        if (n > MAX_ELEMS)
            return MAX_ELEMS;
        return int'(n);
    endfunction

    function automatic longint unsigned floor_root(input logic [SUM_BITS-1:0] x);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned trial;
        rem = 0;
        root = 0;
        for (int i = SUM_BITS / 2 - 1; i >= 0; i--)
        begin
            rem = (rem << 2) | longint'((x >> (2 * i)) & 2'b11);
            trial = (root << 2) | 1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic logic [UNIT_BITS-1:0] q15_quotient(input logic [ELEM_BITS-1:0] e,
                                                          input longint unsigned norm);
        longint unsigned mag;
        longint unsigned q;
        mag = e[ELEM_BITS-1] ? (65536 - longint'(e)) : longint'(e);
        q = (mag << FRAC_BITS) / norm;
        if (e[ELEM_BITS-1])
        begin
            if (q > 32768)
                q = 32768;
            return UNIT_BITS'(65536 - q);
        end
        if (q > 32767)
            q = 32767;
        return UNIT_BITS'(q);
    endfunction

    task automatic take_element(input logic [ELEM_BITS-1:0] v);
        longint unsigned mag;
        longint unsigned root;
        logic zero_vec;
        unit_result_t r;
        if (loaded_count >= MAX_ELEMS)
            loaded_count = MAX_ELEMS - 1;
        elem_mem[loaded_count] = v;
        mag = v[ELEM_BITS-1] ? (65536 - longint'(v)) : longint'(v);
        square_acc = square_acc + SUM_BITS'(mag * mag);
        loaded_count++;
        if (loaded_count < effective_len(length_reg))
            return;
        root = floor_root(square_acc);
        if (root > NORM_MAX)
            root = NORM_MAX;
        zero_vec = (square_acc == 0);
        for (int k = 0; k < loaded_count; k++)
        begin
            r.unit = (zero_vec || root == 0) ? '0 : q15_quotient(elem_mem[k], root);
            r.norm = zero_vec ? '0 : NORM_BITS'(root);
            r.zero = zero_vec;
            r.last = (k == loaded_count - 1);
            pending_units = {pending_units, r};
        end
        vectors_done++;
        square_acc = '0;
        loaded_count = 0;
    endtask

    always @(posedge clk)
    begin : result_check
        unit_result_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (pending_units.size() == 0)
                report_mismatch("result with none expected", unit_element, 0);
            else
            begin
                want = pending_units.pop_front();
                if (unit_element !== want.unit)
                    report_mismatch("unit_element", unit_element, $signed(want.unit));
                if (norm_value !== want.norm)
                    report_mismatch("norm_value", norm_value, want.norm);
                if (zero_norm !== want.zero)
                    report_mismatch("zero_norm", zero_norm, want.zero);
                if (last_element !== want.last)
                    report_mismatch("last_element", last_element, want.last);
            end
        end
    end

    task automatic wait_quiet();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_units.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_element(input logic [ELEM_BITS-1:0] v);
        start <= 1'b1;
        element_value <= v;
        do
            @(posedge clk);
        while (busy);
        take_element(v);
        items_sent++;
    endtask

    task automatic write_length(input logic [LEN_BITS-1:0] n);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data <= n;
        do
            @(posedge clk);
        while (!cfg_ready);
        length_reg = n;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = ($urandom_range(0, 9) < 2) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    function automatic logic [ELEM_BITS-1:0] random_element();
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            v = $urandom;
        else if (pick < 6)
            v = $urandom_range(0, 511) - 256;
        else if (pick == 6)
        begin
            case ($urandom_range(0, 4))
                0: v = 32767;
                1: v = -32768;
                2: v = 1;
                3: v = -1;
                default: v = 0;
            endcase
        end
        else if (pick == 7)
            v = 0;
        else
            v = $urandom_range(0, 8191) - 4096;
        return ELEM_BITS'(v);
    endfunction

    task automatic test_single_element_saturation();
        write_length(LEN_BITS'(1));
        send_element(16'sd32767);
        send_element(-16'sd32768);
        send_element(16'sd1);
        send_element(-16'sd1);
    endtask

    task automatic test_zero_length_setting();
        write_length('0);
        send_element('0);
        send_element(16'sd12345);
    endtask

    task automatic test_norm_saturation();
        write_length({LEN_BITS{1'b1}});
        repeat (MAX_ELEMS) send_element(-16'sd32768);
    endtask

    task automatic test_length_change_mid_load();
        write_length(LEN_BITS'(16));
        send_element('0);
        send_element('0);
        write_length(LEN_BITS'(2));
        send_element('0);
    endtask

    task automatic test_random_vectors();
        int start_items;
        int kind;
        int count;
        int nvec;
        logic [LEN_BITS-1:0] len;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = LEN_BITS'($urandom_range(1, 4));
                5, 6: len = LEN_BITS'($urandom_range(5, 15));
                7: len = LEN_BITS'(16);
                8: len = LEN_BITS'($urandom_range(17, 31));
                default: len = '0;
            endcase
            write_length(len);
            nvec = $urandom_range(1, 4);
            for (int v = 0; v < nvec; v++)
            begin
                kind = $urandom_range(0, 11);
                count = effective_len(len);
                if (kind == 1)
                    count = $urandom_range(1, count);
                for (int k = 0; k < count; k++)
                begin
                    send_element(kind == 0 ? '0 : random_element());
                    pace_sender();
                end
                if (kind == 2)
                    wait_quiet();
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        element_value <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        for (int i = 0; i < MAX_ELEMS; i++)
            elem_mem[i] = '0;
        square_acc = '0;
        loaded_count = 0;
        length_reg = LEN_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_element_saturation();
        test_zero_length_setting();
        test_norm_saturation();
        test_length_change_mid_load();
        test_random_vectors();

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_units.size() != 0)
            report_mismatch("results never received", pending_units.size(), 0);

        $display("Summary: %0d element requests forming %0d vectors, %0d results checked.",
                 items_sent, vectors_done, results_seen);
        $display("Summary: %0d length writes from 0 to 31, bursty requests and quiet pauses.",
                 cfg_writes);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
